// ----- rtl/nlp_pkg.sv -----
// Shared constants and helpers for the numeric literal parser.
// No dependencies.
package nlp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 5;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;  // 'X'
    localparam logic [CHAR_W-1:0] CH_SUF_HEX = 8'h68;  // 'h'
    localparam logic [CHAR_W-1:0] CH_SUF_BIN = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CH_SUF_DEC = 8'h64;  // 'd'

    // Digit value meaning "no digit in any radix"
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    // Radix validity bit positions
    localparam int VALID_HEX = 0;
    localparam int VALID_DEC = 1;
    localparam int VALID_BIN = 2;

    // Saturation limit for the 2-bit counters
    localparam logic [1:0] CNT_MAX = 2'd3;

    typedef logic [VALUE_W-1:0] value_t;

    // Digit value of a byte, DIGIT_NONE for non-digits
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = DIGIT_W'(c - CH_LOWER_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = DIGIT_W'(c - CH_UPPER_A + 8'd10);
        end
        return d;
    endfunction

endpackage

// ----- rtl/numeric_literal_parser_top.sv -----
// Numeric literal parser: one token character per beat, one result per token.
// Depends on nlp_pkg.
//
//  Channel | Dir | tdata            | tuser         | tlast
//  s_      | in  | [7:0] character  | -             | last_char
//  m_      | out | [63:0] number_value | [0] is_number | -
//
// One character per cycle sustained, except while a final character waits on a
// full, stalled output. Each beat is captured in an input register, then the
// radix accumulators and the result are computed in one pass and a result beat
// lands in the output register on the final character, as that character leaves
// the input register. Reset clears all token state and empties both registers.
// A stalled output only holds the pipe when a final character waits behind it.
module numeric_literal_parser_top
    import nlp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
    input  logic               s_tlast,   // last_char
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // [63:0] number_value
    output logic               m_tuser    // [0] is_number
);

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // Token state
    value_t     acc_hex_reg, acc_hex_next;
    value_t     acc_dec_reg, acc_dec_next;
    value_t     acc_bin_reg, acc_bin_next;
    logic [2:0] radix_valid_reg, radix_valid_next;
    logic [1:0] char_pos_reg, char_pos_next;
    logic [1:0] digit_count_reg, digit_count_next;
    logic       neg_reg, neg_next;
    logic       hex_prefix_reg, hex_prefix_next;

    // Output register
    logic   out_valid_reg;
    value_t out_value_reg;
    logic   out_ok_reg;

    logic               advance;
    logic [DIGIT_W-1:0] d;
    logic               is_sign, is_prefix;
    logic [1:0]         prefix_pos;
    value_t             hex_step, dec_step, bin_step;
    logic               res_ok;
    value_t             res_raw, res_value;

    // Pipe moves unless a final character waits on a full, stalled output
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Character classification
    assign d          = digit_value(in_char_reg);
    assign prefix_pos = neg_reg ? 2'd2 : 2'd1;
    assign is_sign    = (char_pos_reg == 2'd0) && (in_char_reg == CH_MINUS);
    assign is_prefix  = !hex_prefix_reg
                        && (in_char_reg == CH_LOWER_X || in_char_reg == CH_UPPER_X)
                        && (char_pos_reg == prefix_pos) && (digit_count_reg == 2'd1)
                        && radix_valid_reg[VALID_DEC] && (acc_dec_reg == '0);

    // One-digit steps of each accumulator
    assign hex_step = {acc_hex_reg[VALUE_W-5:0], d[3:0]};
    assign dec_step = {acc_dec_reg[VALUE_W-4:0], 3'b000}
                    + {acc_dec_reg[VALUE_W-2:0], 1'b0}
                    + VALUE_W'(d[3:0]);
    assign bin_step = {acc_bin_reg[VALUE_W-2:0], d[0]};

    // Next token state
    always_comb begin
        acc_hex_next     = acc_hex_reg;
        acc_dec_next     = acc_dec_reg;
        acc_bin_next     = acc_bin_reg;
        radix_valid_next = radix_valid_reg;
        char_pos_next    = char_pos_reg;
        digit_count_next = digit_count_reg;
        neg_next         = neg_reg;
        hex_prefix_next  = hex_prefix_reg;
        if (in_last_reg) begin
            // back to reset state for the next token
            acc_hex_next     = '0;
            acc_dec_next     = '0;
            acc_bin_next     = '0;
            radix_valid_next = 3'b111;
            char_pos_next    = 2'd0;
            digit_count_next = 2'd0;
            neg_next         = 1'b0;
            hex_prefix_next  = 1'b0;
        end else begin
            if (is_sign) begin
                neg_next = 1'b1;
            end else if (is_prefix) begin
                hex_prefix_next  = 1'b1;
                acc_hex_next     = '0;
                radix_valid_next = 3'b000;
                radix_valid_next[VALID_HEX] = 1'b1;
                digit_count_next = 2'd0;
            end else begin
                if (d < 5'd16) acc_hex_next = hex_step;
                else           radix_valid_next[VALID_HEX] = 1'b0;
                if (d < 5'd10) acc_dec_next = dec_step;
                else           radix_valid_next[VALID_DEC] = 1'b0;
                if (d < 5'd2)  acc_bin_next = bin_step;
                else           radix_valid_next[VALID_BIN] = 1'b0;
                if (digit_count_reg != CNT_MAX) begin
                    digit_count_next = digit_count_reg + 2'd1;
                end
            end
            if (char_pos_reg != CNT_MAX) begin
                char_pos_next = char_pos_reg + 2'd1;
            end
        end
    end

    // Radix decision on the final character
    always_comb begin
        res_ok  = 1'b0;
        res_raw = '0;
        if (is_sign || is_prefix) begin
            res_ok = 1'b0;
        end else if (hex_prefix_reg) begin
            res_ok  = radix_valid_reg[VALID_HEX] && (d < 5'd16);
            res_raw = hex_step;
        end else begin
            case (in_char_reg)
                CH_SUF_HEX: begin
                    res_ok  = (digit_count_reg != 2'd0) && radix_valid_reg[VALID_HEX];
                    res_raw = acc_hex_reg;
                end
                CH_SUF_BIN: begin
                    res_ok  = (digit_count_reg != 2'd0) && radix_valid_reg[VALID_BIN];
                    res_raw = acc_bin_reg;
                end
                CH_SUF_DEC: begin
                    res_ok  = (digit_count_reg != 2'd0) && radix_valid_reg[VALID_DEC];
                    res_raw = acc_dec_reg;
                end
                default: begin
                    res_ok  = radix_valid_reg[VALID_DEC] && (d < 5'd10);
                    res_raw = dec_step;
                end
            endcase
        end
        if (!res_ok)      res_value = '0;
        else if (neg_reg) res_value = '0 - res_raw;
        else              res_value = res_raw;
    end

    // Token state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_hex_reg     <= '0;
            acc_dec_reg     <= '0;
            acc_bin_reg     <= '0;
            radix_valid_reg <= 3'b111;
            char_pos_reg    <= 2'd0;
            digit_count_reg <= 2'd0;
            neg_reg         <= 1'b0;
            hex_prefix_reg  <= 1'b0;
        end else if (advance) begin
            acc_hex_reg     <= acc_hex_next;
            acc_dec_reg     <= acc_dec_next;
            acc_bin_reg     <= acc_bin_next;
            radix_valid_reg <= radix_valid_next;
            char_pos_reg    <= char_pos_next;
            digit_count_reg <= digit_count_next;
            neg_reg         <= neg_next;
            hex_prefix_reg  <= hex_prefix_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            out_value_reg <= res_value;
            out_ok_reg    <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_ok_reg;

endmodule

// ----- tb/sv/nlp_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the numeric literal parser: predicts each token's result from its beats.
// Depends on nlp_pkg for widths, character codes and radix bit positions.
package nlp_tb_pkg;
    import nlp_pkg::*;

    typedef struct packed {
        logic   is_num;
        value_t value;
    } literal_t;

    class literal_scoreboard;
        // token state, mirrors what the block holds between beats
        value_t     acc_hex;
        value_t     acc_dec;
        value_t     acc_bin;
        logic [2:0] radix_ok;
        logic [1:0] pos;
        logic [1:0] digits;
        logic       neg;
        logic       hex_pfx;

        literal_t   pending[$];
        int         mismatches;

        function new();
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            acc_hex  = '0;
            acc_dec  = '0;
            acc_bin  = '0;
            radix_ok = '1;
            pos      = '0;
            digits   = '0;
            neg      = 1'b0;
            hex_pfx  = 1'b0;
        endfunction

        // value of a byte as a digit, DIGIT_NONE when it is none
        function logic [DIGIT_W-1:0] digit_of(logic [CHAR_W-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
            if (c >= CH_LOWER_A && c <= CH_LOWER_F) return DIGIT_W'(c - CH_LOWER_A + 10);
            if (c >= CH_UPPER_A && c <= CH_UPPER_F) return DIGIT_W'(c - CH_UPPER_A + 10);
            return DIGIT_NONE;
        endfunction

        function void add_digit(logic [DIGIT_W-1:0] d);
            if (d < 16) acc_hex = acc_hex * 64'd16 + VALUE_W'(d);
            else radix_ok[VALID_HEX] = 1'b0;
            if (d < 10) acc_dec = acc_dec * 64'd10 + VALUE_W'(d);
            else radix_ok[VALID_DEC] = 1'b0;
            if (d < 2) acc_bin = acc_bin * 64'd2 + VALUE_W'(d);
            else radix_ok[VALID_BIN] = 1'b0;
            if (digits != CNT_MAX) digits = digits + 2'd1;
        endfunction

        // one accepted input beat; a final character queues the expected result
        function void note_char(logic [CHAR_W-1:0] c, logic last);
            logic [DIGIT_W-1:0] d;
            logic               sign_ch;
            logic               pfx_ch;
            logic               ok;
            value_t             v;
            literal_t           res;
            d       = digit_of(c);
            sign_ch = (pos == 2'd0) && (c == CH_MINUS);
            pfx_ch  = !hex_pfx && (c == CH_LOWER_X || c == CH_UPPER_X) &&
                      pos == (neg ? 2'd2 : 2'd1) && digits == 2'd1 &&
                      radix_ok[VALID_DEC] && acc_dec == '0;
            if (!last) begin
                if (sign_ch) begin
                    neg = 1'b1;
                end else if (pfx_ch) begin
                    hex_pfx  = 1'b1;
                    acc_hex  = '0;
                    radix_ok = '0;
                    radix_ok[VALID_HEX] = 1'b1;
                    digits   = '0;
                end else begin
                    add_digit(d);
                end
                if (pos != CNT_MAX) pos = pos + 2'd1;
                return;
            end

            // final character decides the radix
            ok = 1'b0;
            v  = '0;
            if (sign_ch || pfx_ch) begin
                ok = 1'b0;
            end else if (hex_pfx) begin
                ok = radix_ok[VALID_HEX] && d < 16;
                v  = acc_hex * 64'd16 + VALUE_W'(d);
            end else if (c == CH_SUF_HEX) begin
                ok = digits != 0 && radix_ok[VALID_HEX];
                v  = acc_hex;
            end else if (c == CH_SUF_BIN) begin
                ok = digits != 0 && radix_ok[VALID_BIN];
                v  = acc_bin;
            end else if (c == CH_SUF_DEC) begin
                ok = digits != 0 && radix_ok[VALID_DEC];
                v  = acc_dec;
            end else begin
                ok = radix_ok[VALID_DEC] && d < 10;
                v  = acc_dec * 64'd10 + VALUE_W'(d);
            end
            if (!ok) v = '0;
            else if (neg) v = -v;
            res.is_num = ok;
            res.value  = v;
            pending.push_back(res);
            clear_token();
        endfunction

        task report_mismatch(string what, value_t want, value_t got);
            $display("mismatch %s: expected %h, got %h", what, want, got);
            mismatches++;
        endtask

        // one accepted result beat against the oldest token
        task check_result(logic is_num, value_t value);
            literal_t want;
            if (pending.size() == 0) begin
                report_mismatch("result beat with no token pending", '0, value);
                return;
            end
            want = pending.pop_front();
            if (is_num !== want.is_num)
                report_mismatch("is_number", VALUE_W'(want.is_num), VALUE_W'(is_num));
            if (value !== want.value)
                report_mismatch("number_value", want.value, value);
        endtask

        task check_drained();
            if (pending.size() != 0)
                report_mismatch("tokens without result", '0, VALUE_W'(pending.size()));
        endtask
    endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the numeric literal parser testbench: clock, reset, beat drivers and result monitor.
// Depends on nlp_pkg, nlp_tb_pkg and numeric_literal_parser_top.
module testbench
    import nlp_pkg::*;
    import nlp_tb_pkg::*;
();

    localparam int RANDOM_CHARS = 1500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRESSURE_LEN = 400;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;
    logic               m_tuser;

    literal_scoreboard  sb;
    logic [CHAR_W-1:0]  tok[$];
    int                 chars_sent  = 0;
    int                 tx_calm     = 0;
    int                 rx_calm     = 0;
    bit                 random_on   = 1'b0;

    numeric_literal_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // mostly no gap, some short, a few long, with calm stretches now and then
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(50, 150);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic l);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(c, l);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_token();
        for (int i = 0; i < tok.size(); i++)
            send_beat(tok[i], i == tok.size() - 1);
        tok.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] hex_char();
        string set;
        set = "0123456789abcdefABCDEF";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // random token: mostly well-formed literals, the rest noise or broken ones
    task automatic make_token();
        int          kind;
        int          n;
        logic [CHAR_W-1:0] c;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) tok.push_back(CH_MINUS);
        if ($urandom_range(0, 15) == 0) n = $urandom_range(15, (kind == 5) ? 70 : 24);
        else n = $urandom_range(1, 5);
        case (kind)
            3: begin
                push_text($urandom_range(0, 1) ? "0x" : "0X");
                for (int i = 0; i < n; i++) tok.push_back(hex_char());
            end
            4: begin
                for (int i = 0; i < n; i++) tok.push_back(hex_char());
                tok.push_back(CH_SUF_HEX);
            end
            5: begin
                for (int i = 0; i < n; i++)
                    tok.push_back($urandom_range(0, 11) == 0 ? hex_char()
                                  : CHAR_W'(CH_ZERO + $urandom_range(0, 1)));
                tok.push_back(CH_SUF_BIN);
            end
            6: begin
                for (int i = 0; i < n; i++)
                    tok.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                tok.push_back(CH_SUF_DEC);
            end
            7: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) tok.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            8: begin
                // digits with a stray byte or a sign inserted at a random position
                for (int i = 0; i < n; i++)
                    tok.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                c = $urandom_range(0, 1) ? CH_MINUS : CHAR_W'($urandom_range(0, 255));
                tok.insert($urandom_range(0, tok.size()), c);
            end
            9: begin
                // prefix near-misses and prefix followed by a suffix letter
                case ($urandom_range(0, 3))
                    0: push_text("0x");
                    1: push_text("00x1");
                    2: push_text("7x1");
                    default: begin
                        push_text("0X");
                        for (int i = 0; i < n - 1; i++) tok.push_back(hex_char());
                    end
                endcase
                case ($urandom_range(0, 3))
                    0: tok.push_back(CH_SUF_HEX);
                    1: tok.push_back(CH_SUF_BIN);
                    2: tok.push_back(CH_SUF_DEC);
                    default: ;
                endcase
            end
            default: begin
                for (int i = 0; i < n; i++)
                    tok.push_back($urandom_range(0, 15) == 0 ? hex_char()
                                  : CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
            end
        endcase
    endtask

    // result side: random stalls, one long hold-off once random traffic starts
    initial begin
        int  hold;
        bit  pressed;
        hold    = 0;
        pressed = 1'b0;
        forever begin
            @(negedge aclk);
            if (random_on && !pressed) begin
                pressed = 1'b1;
                hold    = PRESSURE_LEN;
            end
            if (hold == 0) hold = pick_gap(rx_calm);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // run time guard
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int drain;
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed tokens: sign, prefix and suffix alone, suffix after prefix, byte extremes
        push_text("-");     send_token();
        push_text("0x");    send_token();
        push_text("-0x");   send_token();
        push_text("h");     send_token();
        push_text("-d");    send_token();
        push_text("0x1h");  send_token();
        push_text("0Xfb");  send_token();
        push_text("101b");  send_token();
        tok.push_back(8'h00); send_token();
        tok.push_back(8'hFF); send_token();
        push_text("7");     send_token();

        random_on = 1'b1;
        while (chars_sent < RANDOM_CHARS) begin
            make_token();
            send_token();
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then allow for pipeline latency
        drain = 0;
        while (sb.pending.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
